@@ design/hvs_pkg.sv @@
// shared types, constants and elaboration-time table functions for the haversine datapath
package hvs_pkg;

  typedef logic signed [43:0] cq40_t;
  typedef logic [33:0] turn_t;
  typedef logic [33:0] dist_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  localparam logic [15:0] EARTH_RADIUS = 16'd6371;
  localparam logic [26:0] RECIP45      = 27'd95443717;
  localparam logic [40:0] OFFSET45     = 41'd773094113280;
  localparam logic [30:0] PI_Q29       = 31'h6487ED51;
  localparam logic [63:0] PI_Q61       = 64'h6487ED5110B4611A;
  localparam dist_t       DIST_MAX     = 34'd13493037705;
  localparam int          TABLE_LEN    = 32;

  // restoring division, used only for constants
  function automatic logic [63:0] hvs_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] hvs_isqrt_c(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] b;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(2^-i) in Q40 from the alternating series
  function automatic logic [63:0] hvs_atan(input int i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 e;
    sum = '0;
    if (i == 0) begin
      return (PI_Q61 + (64'd1 << 22)) >> 23;
    end
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = hvs_udiv(64'd1 << e, 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    return 64'((sum + 64'sd2097152) >>> 22);
  endfunction

  // inverse cordic gain in Q40 for a given number of micro-rotations
  function automatic logic [63:0] hvs_gain(input int steps);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] g;
    p = 64'd1 << 60;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i < steps) begin
        p = p + (p >> (2 * i));
      end
    end
    s = hvs_isqrt_c(p);
    g = hvs_udiv((64'd1 << 62) + (s >> 1), s);
    return g << 8;
  endfunction

  // Q40 to Q30, round half up
  function automatic logic signed [31:0] hvs_to_q30(input cq40_t v);
    cq40_t t;
    t = v + 44'sd512;
    return t[41:10];
  endfunction

endpackage

@@ design/hvs_if.sv @@
// request and result channel interfaces
interface hvs_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] start_latitude;
  logic signed [31:0] start_longitude;
  logic signed [30:0] end_latitude;
  logic signed [31:0] end_longitude;
  modport source (output valid, start_latitude, start_longitude, end_latitude, end_longitude,
                  input ready);
  modport sink (input valid, start_latitude, start_longitude, end_latitude, end_longitude,
                output ready);
endinterface

interface hvs_out_if;
  logic        valid;
  logic        ready;
  logic [33:0] great_circle_distance;
  modport source (output valid, great_circle_distance, input ready);
  modport sink (input valid, great_circle_distance, output ready);
endinterface

@@ design/hvs_deg2turn.sv @@
// degrees times 2^23 to binary angle of 2^-34 turn, divide by 45 in two digits
module hvs_deg2turn import hvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_i,
  input  logic signed [31:0] deg_i,
  output logic               valid_o,
  output turn_t              turn_o
);

  logic [40:0] n_c;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [47:0] ph_r;
  logic [20:0] nh1_r;
  logic [19:0] nl1_r, nl2_r;
  logic [15:0] qh_est, qh_c, qh2_r, qh3_r;
  logic [21:0] rh_c;
  logic [5:0]  rh2_r;
  logic [25:0] m3_r;
  logic [52:0] pl_r;
  logic [20:0] ql_est;
  logic [19:0] ql_c;
  logic [26:0] rl_c;
  turn_t       turn_r;

  // floor((256*deg + 22) / 45), kept positive by a multiple of 45 * 2^34
  assign n_c = 41'({{9{deg_i[31]}}, deg_i} << 8) + 41'd22 + OFFSET45;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    qh_est = ph_r[47:32];
    rh_c   = 22'(nh1_r) - 22'(qh_est * 22'd45);
    qh_c   = qh_est;
    if (rh_c >= 22'd45) begin
      qh_c = qh_est + 16'd1;
      rh_c = rh_c - 22'd45;
    end
  end

  always_comb begin
    ql_est = pl_r[52:32];
    rl_c   = 27'(m3_r) - 27'(ql_est * 27'd45);
    ql_c   = ql_est[19:0];
    if (rl_c >= 27'd45) begin
      ql_c = ql_est[19:0] + 20'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r   <= 48'(n_c[40:20]) * 48'(RECIP45);
      nh1_r  <= n_c[40:20];
      nl1_r  <= n_c[19:0];
      qh2_r  <= qh_c;
      rh2_r  <= rh_c[5:0];
      nl2_r  <= nl1_r;
      m3_r   <= {rh2_r, nl2_r};
      pl_r   <= 53'({rh2_r, nl2_r}) * 53'(RECIP45);
      qh3_r  <= qh2_r;
      turn_r <= {qh3_r[13:0], ql_c};
    end
  end

  assign valid_o = v4_r;
  assign turn_o  = turn_r;

endmodule

@@ design/hvs_cordic_rot.sv @@
// pipelined rotation cordic: sine and cosine of a 35 bit binary angle, Q40
module hvs_cordic_rot import hvs_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        valid_i,
  input  logic [34:0] angle_i,
  output logic        valid_o,
  output cq40_t       sin_o,
  output cq40_t       cos_o
);

  localparam int    STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam cq40_t GAIN  = cq40_t'(hvs_gain(STEPS));

  logic        v_r [STEPS+1];
  cq40_t       x_r [STEPS+1];
  cq40_t       y_r [STEPS+1];
  cq40_t       z_r [STEPS+1];
  quad_t       q_r [STEPS+1];
  logic [63:0] z0_c;
  logic        vo_r;
  cq40_t       sin_r, cos_r;

  assign z0_c = 64'(angle_i[32:0]) * 64'(PI_Q29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= GAIN;
      y_r[0] <= '0;
      z_r[0] <= cq40_t'({3'b000, z0_c[63:23]});
      q_r[0] <= quad_t'(angle_i[34:33]);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam cq40_t ATAN = cq40_t'(hvs_atan(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][43]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= v_r[STEPS];
    end
  end

  // fold the quarter turn back in
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (q_r[STEPS])
        QUAD_I: begin
          sin_r <= y_r[STEPS];
          cos_r <= x_r[STEPS];
        end
        QUAD_II: begin
          sin_r <= x_r[STEPS];
          cos_r <= -y_r[STEPS];
        end
        QUAD_III: begin
          sin_r <= -y_r[STEPS];
          cos_r <= -x_r[STEPS];
        end
        QUAD_IV: begin
          sin_r <= -x_r[STEPS];
          cos_r <= y_r[STEPS];
        end
        default: begin
          sin_r <= y_r[STEPS];
          cos_r <= x_r[STEPS];
        end
      endcase
    end
  end

  assign valid_o = vo_r;
  assign sin_o   = sin_r;
  assign cos_o   = cos_r;

endmodule

@@ design/hvs_isqrt.sv @@
// pipelined bitwise integer square root of a 61 bit value, one result bit per stage
module hvs_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        valid_i,
  input  logic [60:0] rad_i,
  output logic        valid_o,
  output logic [30:0] root_o
);

  localparam int NSTG = 31;

  logic        v_r    [NSTG+1];
  logic [61:0] rem_r  [NSTG+1];
  logic [61:0] root_r [NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= 62'(rad_i);
      root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_r[j] >= root_r[j] + BIT) begin
          rem_r[j+1]  <= rem_r[j] - (root_r[j] + BIT);
          root_r[j+1] <= (root_r[j] >> 1) + BIT;
        end else begin
          rem_r[j+1]  <= rem_r[j];
          root_r[j+1] <= root_r[j] >> 1;
        end
      end
    end
  end

  assign valid_o = v_r[NSTG];
  assign root_o  = root_r[NSTG][30:0];

endmodule

@@ design/hvs_cordic_vec.sv @@
// pipelined vectoring cordic: angle of (x, y) in Q40
module hvs_cordic_vec import hvs_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  valid_i,
  input  cq40_t x_i,
  input  cq40_t y_i,
  output logic  valid_o,
  output cq40_t angle_o
);

  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  logic  v_r [STEPS+1];
  cq40_t x_r [STEPS+1];
  cq40_t y_r [STEPS+1];
  cq40_t z_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= x_i;
      y_r[0] <= y_i;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam cq40_t ATAN = cq40_t'(hvs_atan(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    // drive y toward zero
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_r[i][43]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  assign valid_o = v_r[STEPS];
  assign angle_o = z_r[STEPS];

endmodule

@@ design/haversine_distance_core.sv @@
// haversine great-circle distance core, fully pipelined
// throughput: one request per cycle unless the skid register holds a result;
//   every cordic micro-rotation and square root bit has its own pipeline stage,
//   and a two-entry output register absorbs a stalled result
// reset (synchronous, rst_n low): all valid bits cleared, sphere radius set to 6371
module haversine_distance_core import hvs_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  hvs_in_if.sink      in_chan,
  hvs_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        adv;
  logic [15:0] radius_r;

  // angle conversion
  logic  d_v;
  turn_t t1, t2, t3, t4;

  // angle differences
  logic        b_v_r;
  logic [34:0] a_dlat_r, a_dlon_r, a_lat1_r, a_lat2_r;

  // sines and cosines
  logic  r_v;
  cq40_t s_dlat, s_dlon, c_lat1, c_lat2;

  // haversine term
  logic               c1_v_r, c2_v_r, c3_v_r, c4_v_r, c5_v_r;
  logic signed [31:0] sl_r, so_r, k1_r, k2_r;
  logic [31:0]        msl_c, mso_c;
  logic [63:0]        sql_c, sqo_c;
  logic [31:0]        hl2_r, ho2_r, hl3_r, ho3_r, hl4_r;
  logic signed [63:0] p_r;
  logic [63:0]        pm_c, mq_c, tp_c;
  logic [31:0]        mq_r;
  logic               neg3_r, neg4_r;
  logic [33:0]        term_r;
  logic signed [35:0] a_c;
  logic [30:0]        a_r;

  // roots and central angle
  logic        h_v;
  logic [30:0] h_root, g_root;
  logic        vec_v;
  cq40_t       half_ang;

  // scaling and output
  logic        f_v_r;
  logic [58:0] prod_r;
  logic [59:0] dr_c;
  dist_t       dist_c;
  logic        out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  dist_t       out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= EARTH_RADIUS;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // the whole pipeline moves unless the skid register is holding a result
  assign adv           = !skid_v_r;
  assign in_chan.ready = adv;

  hvs_deg2turn u_t1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(in_chan.valid),
    .deg_i(32'(in_chan.start_latitude)), .valid_o(d_v), .turn_o(t1)
  );
  hvs_deg2turn u_t2 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(in_chan.valid),
    .deg_i(in_chan.start_longitude), .valid_o(), .turn_o(t2)
  );
  hvs_deg2turn u_t3 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(in_chan.valid),
    .deg_i(32'(in_chan.end_latitude)), .valid_o(), .turn_o(t3)
  );
  hvs_deg2turn u_t4 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(in_chan.valid),
    .deg_i(in_chan.end_longitude), .valid_o(), .turn_o(t4)
  );

  // half angles of the differences, full angles of the latitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dlat_r <= {1'b0, 34'(t3 - t1)};
      a_dlon_r <= {1'b0, 34'(t4 - t2)};
      a_lat1_r <= {t1, 1'b0};
      a_lat2_r <= {t3, 1'b0};
    end
  end

  hvs_cordic_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(b_v_r), .angle_i(a_dlat_r),
    .valid_o(r_v), .sin_o(s_dlat), .cos_o()
  );
  hvs_cordic_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(b_v_r), .angle_i(a_dlon_r),
    .valid_o(), .sin_o(s_dlon), .cos_o()
  );
  hvs_cordic_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(b_v_r), .angle_i(a_lat1_r),
    .valid_o(), .sin_o(), .cos_o(c_lat1)
  );
  hvs_cordic_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(b_v_r), .angle_i(a_lat2_r),
    .valid_o(), .sin_o(), .cos_o(c_lat2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
      c5_v_r <= 1'b0;
    end else if (adv) begin
      c1_v_r <= r_v;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
      c4_v_r <= c3_v_r;
      c5_v_r <= c4_v_r;
    end
  end

  always_comb begin
    msl_c = sl_r[31] ? 32'(-sl_r) : 32'(sl_r);
    mso_c = so_r[31] ? 32'(-so_r) : 32'(so_r);
    sql_c = 64'(msl_c) * 64'(mso_c & 32'd0 | msl_c) + 64'd536870912;
    sqo_c = 64'(mso_c) * 64'(mso_c) + 64'd536870912;
    pm_c  = p_r[63] ? 64'(-p_r) : 64'(p_r);
    mq_c  = pm_c + 64'd536870912;
    tp_c  = 64'(mq_r) * 64'(ho3_r) + 64'd536870912;
    a_c   = neg4_r ? (36'(hl4_r) - 36'(term_r)) : (36'(hl4_r) + 36'(term_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_r   <= hvs_to_q30(s_dlat);
      so_r   <= hvs_to_q30(s_dlon);
      k1_r   <= hvs_to_q30(c_lat1);
      k2_r   <= hvs_to_q30(c_lat2);
      hl2_r  <= sql_c[61:30];
      ho2_r  <= sqo_c[61:30];
      p_r    <= 64'(k1_r) * 64'(k2_r);
      mq_r   <= mq_c[61:30];
      neg3_r <= p_r[63];
      hl3_r  <= hl2_r;
      ho3_r  <= ho2_r;
      term_r <= tp_c[63:30];
      neg4_r <= neg3_r;
      hl4_r  <= hl3_r;
      // clamp a to [0, 1] in Q30
      if (a_c[35]) begin
        a_r <= '0;
      end else if (a_c > 36'sd1073741824) begin
        a_r <= 31'd1073741824;
      end else begin
        a_r <= a_c[30:0];
      end
    end
  end

  hvs_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(c5_v_r),
    .rad_i({a_r[30:0], 30'd0}), .valid_o(h_v), .root_o(h_root)
  );
  hvs_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(c5_v_r),
    .rad_i({31'(31'd1073741824 - a_r), 30'd0}), .valid_o(), .root_o(g_root)
  );

  hvs_cordic_vec #(.CORDIC_STEPS(CORDIC_STEPS)) u_vec (
    .clk(clk), .rst_n(rst_n), .adv(adv), .valid_i(h_v),
    .x_i({3'b000, g_root, 10'd0}), .y_i({3'b000, h_root, 10'd0}),
    .valid_o(vec_v), .angle_o(half_ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= half_ang[43] ? '0 : 59'(half_ang[42:0]) * 59'(radius_r);
    end
  end

  always_comb begin
    dr_c   = 60'(prod_r) + 60'd4194304;
    dist_c = (dr_c[59:23] > 37'(DIST_MAX)) ? DIST_MAX : dr_c[56:23];
  end

  // output register with one skid entry behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && out_chan.ready) begin
      out_v_nxt = 1'b0;
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end
    if (adv && f_v_r) begin
      if (!out_v_nxt) begin
        out_v_nxt = 1'b1;
        out_d_nxt = dist_c;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = dist_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_chan.valid                 = out_v_r;
  assign out_chan.great_circle_distance = out_d_r;

endmodule

@@ design/hvs_checker.sv @@
// port-level checks on the haversine core, bound to the top level
module hvs_checker import hvs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [33:0] out_dist
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dist))
    else $error("result changed or dropped while stalled");

  // requests are refused only while a result is waiting
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request refused with no result pending");

  // a full output side stays full until the result is taken
  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("stall released without a result taken");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dist <= DIST_MAX)
    else $error("distance above saturation limit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind haversine_distance_core hvs_checker u_hvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_dist  (out_chan.great_circle_distance)
);
